// File: src/vtu_pkg.sv
// Shared types and constants of the vertex transform unit.
// Used by the square root unit and the top level.
package vtu_pkg;

  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = FIELD_W + 1;

  // matrix register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_M11_M12 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_M13_M14 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M21_M22 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M23_M24 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M31_M32 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_M33_M34 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_M41_M42 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_M43_M44 = 3'd7;

  // normal is normalized so the largest magnitude lies in [2^29, 2^30)
  localparam int NRM_BITS = 30;
  localparam int NRM_TOP  = NRM_BITS - 1;
  localparam int SQ_W     = 2 * NRM_BITS;
  localparam int SUMSQ_W  = SQ_W + 2;

  // square root: 64-bit radicand, one result bit per stage
  localparam int ISQ_W     = 64;
  localparam int ISQ_STEPS = 32;
  localparam int ROOT_W    = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] norm_x;
    logic signed [FIELD_W-1:0] norm_y;
    logic signed [FIELD_W-1:0] norm_z;
    logic signed [FIELD_W-1:0] tex_u;
    logic signed [FIELD_W-1:0] tex_v;
    logic                      last_vertex;
  } vtu_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_nx;
    logic signed [FIELD_W-1:0] out_ny;
    logic signed [FIELD_W-1:0] out_nz;
    logic signed [FIELD_W-1:0] out_u;
    logic signed [FIELD_W-1:0] out_v;
    logic                      out_last;
    logic                      w_zero;
    logic                      normal_zero;
    logic                      saturated;
  } vtu_out_t;

endpackage

// File: src/vtu_stream_if.sv
// Valid/ready stream channel carrying one payload struct per transfer.
// Payload types come from vtu_pkg.
interface vtu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/vtu_div_pipe.sv
// Pipelined unsigned long divider, one quotient bit per stage.
// Needs rem_in < den_in; each stage is registered and advances when en is high.
module vtu_div_pipe #(
  parameter int DEN_W  = 58,
  parameter int Q_BITS = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W-1:0]  rem_in,
  input  logic [Q_BITS-1:0] lo_in,
  input  logic [DEN_W-1:0]  den_in,
  output logic [Q_BITS-1:0] quo
);

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [Q_BITS-1:0] lo;
    logic [DEN_W-1:0]  den;
    logic [Q_BITS-1:0] q;
  } dstep_t;

  function automatic dstep_t div_step(dstep_t s);
    logic [DEN_W:0] t;
    dstep_t         o;
    t    = {s.rem, s.lo[Q_BITS-1]};
    o    = s;
    o.lo = {s.lo[Q_BITS-2:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      o.rem = DEN_W'(t - {1'b0, s.den});
      o.q   = {s.q[Q_BITS-2:0], 1'b1};
    end else begin
      o.rem = t[DEN_W-1:0];
      o.q   = {s.q[Q_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  dstep_t head;
  dstep_t st_r [Q_BITS];

  always_comb begin
    head.rem = rem_in;
    head.lo  = lo_in;
    head.den = den_in;
    head.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(head);
      for (int k = 1; k < Q_BITS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign quo = st_r[Q_BITS-1].q;

endmodule

// File: src/vtu_isqrt_pipe.sv
// Pipelined integer square root, floor(sqrt(n)), one result bit per stage.
// Uses vtu_pkg widths; the stages are registered and advance on en.
module vtu_isqrt_pipe (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vtu_pkg::ISQ_W-1:0]  n_in,
  output logic [vtu_pkg::ROOT_W-1:0] root
);

  typedef struct packed {
    logic [vtu_pkg::ISQ_W-1:0] num;
    logic [vtu_pkg::ISQ_W-1:0] res;
  } sstep_t;

  function automatic sstep_t sqrt_step(sstep_t s, int k);
    logic [vtu_pkg::ISQ_W-1:0] bitv;
    logic [vtu_pkg::ISQ_W-1:0] trial;
    sstep_t                    o;
    bitv  = vtu_pkg::ISQ_W'(1) << (vtu_pkg::ISQ_W - 2 - 2 * k);
    trial = s.res + bitv;
    o     = s;
    if (s.num >= trial) begin
      o.num = s.num - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  sstep_t head;
  sstep_t st_r [vtu_pkg::ISQ_STEPS];

  always_comb begin
    head.num = n_in;
    head.res = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= sqrt_step(head, 0);
      for (int k = 1; k < vtu_pkg::ISQ_STEPS; k++) begin
        st_r[k] <= sqrt_step(st_r[k-1], k);
      end
    end
  end

  assign root = st_r[vtu_pkg::ISQ_STEPS-1].res[vtu_pkg::ROOT_W-1:0];

endmodule

// File: src/vertex_transform_unit.sv
// Vertex transform: 4x4 matrix, perspective divide, normal renormalize.
// Depends on vtu_pkg, vtu_stream_if, vtu_div_pipe and vtu_isqrt_pipe.
//
// Usage:
//   in_ch carries one vertex per transfer (position, normal, texture
//   coordinates, last mark); out_ch returns one result per vertex, in order.
//   The matrix is written through cfg_we/cfg_index/cfg_wdata, one 64-bit
//   register per write. The user must write it only while no vertex is in
//   flight; the block does not enforce this. Throughput: one vertex per
//   cycle while out_ch does not stall. The path from the input transfer to
//   out_ch.valid is set by the 32-stage square root followed by the
//   FRAC_BITS + 1 stage normal divider; the position divider
//   (COORD_WIDTH-limited, one bit per stage) runs alongside, delay-matched.
//   Reset (rst_n low at a clock edge) empties the pipeline and loads the
//   identity matrix.
//   When out_ch.ready is low with a result waiting, the whole pipeline
//   holds and in_ch.ready drops; bubbles in flight hold their places.
module vertex_transform_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vtu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtu_pkg::CFG_W-1:0]       cfg_wdata,
  vtu_stream_if.sink                      in_ch,
  vtu_stream_if.source                    out_ch
);

  localparam int FW     = vtu_pkg::FIELD_W;
  localparam int F      = FRAC_BITS;
  localparam int OUT_W  = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam int PROD_W = 2 * FW;
  localparam int ACC_W  = PROD_W - F + 2;
  localparam int NUM_W  = ACC_W + F;
  localparam int QB     = OUT_W + 1;
  localparam int QN     = F + 1;
  localparam int NG     = (ACC_W + 7) / 8;
  localparam int GW     = $clog2(NG);
  localparam int PW     = GW + 3;
  localparam int SW     = vtu_pkg::SAT_W;
  // stage numbering: stage s registers are loaded from stage s-1
  localparam int S_ROOT = 8 + vtu_pkg::ISQ_STEPS;
  localparam int S_END  = S_ROOT + QN;
  localparam int LAT    = S_END + 1;
  localparam int PDLY   = S_END - (4 + QB);
  localparam int M_DLY  = S_ROOT - 6;
  localparam int PASS_W = 2 * FW + 1;
  localparam logic [vtu_pkg::CFG_W-1:0] ONE = vtu_pkg::CFG_W'(1) << F;

  // ---------------------------------------------------------------- config
  logic [vtu_pkg::CFG_W-1:0] cfg_r [vtu_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vtu_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
      cfg_r[vtu_pkg::REG_M11_M12] <= ONE;
      cfg_r[vtu_pkg::REG_M21_M22] <= ONE << FW;
      cfg_r[vtu_pkg::REG_M33_M34] <= ONE;
      cfg_r[vtu_pkg::REG_M43_M44] <= ONE << FW;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  logic signed [FW-1:0] mat [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = cfg_r[2 * r + c / 2][FW * (c % 2) +: FW];
      end
    end
  end

  // -------------------------------------------------------------- control
  logic           en;
  logic [LAT:1]   vld_r;

  assign en          = out_ch.ready || !vld_r[LAT];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_ch.valid};
    end
  end

  // ------------------------------------------------- stage 1: products
  logic signed [FW-1:0]     pin [3];
  logic signed [FW-1:0]     nin [3];
  logic signed [PROD_W-1:0] pprod_r [3][4];
  logic signed [PROD_W-1:0] nprod_r [3][3];

  assign pin[0] = in_ch.data.pos_x;
  assign pin[1] = in_ch.data.pos_y;
  assign pin[2] = in_ch.data.pos_z;
  assign nin[0] = in_ch.data.norm_x;
  assign nin[1] = in_ch.data.norm_y;
  assign nin[2] = in_ch.data.norm_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          pprod_r[r][c] <= pin[r] * mat[r][c];
        end
        for (int c = 0; c < 3; c++) begin
          nprod_r[r][c] <= nin[r] * mat[r][c];
        end
      end
    end
  end

  // --------------------------------------- stage 2: floor and accumulate
  logic signed [ACC_W-1:0] pacc_nxt [4];
  logic signed [ACC_W-1:0] nacc_nxt [3];
  logic signed [ACC_W-1:0] pacc_r [4];
  logic signed [ACC_W-1:0] nacc_r [3];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pacc_nxt[c] = ACC_W'(mat[3][c]);
      for (int r = 0; r < 3; r++) begin
        pacc_nxt[c] = pacc_nxt[c] + ACC_W'(pprod_r[r][c] >>> F);
      end
    end
    for (int c = 0; c < 3; c++) begin
      nacc_nxt[c] = '0;
      for (int r = 0; r < 3; r++) begin
        nacc_nxt[c] = nacc_nxt[c] + ACC_W'(nprod_r[r][c] >>> F);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pacc_r <= pacc_nxt;
      nacc_r <= nacc_nxt;
    end
  end

  // --------------------------------------- stage 3: magnitudes and signs
  logic [ACC_W-1:0] ux_r [3];
  logic [ACC_W-1:0] uw_r;
  logic [2:0]       pneg_r;
  logic             wz_r;
  logic [ACC_W-1:0] nmag_r [3];
  logic [ACC_W-1:0] orw_r;
  logic [3:0]       nside_nxt;
  logic [2:0]       nneg_r;

  function automatic logic [ACC_W-1:0] nacc_nxt_or(logic signed [ACC_W-1:0] a [3]);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] o;
    o = '0;
    for (int c = 0; c < 3; c++) begin
      m = a[c][ACC_W-1] ? ACC_W'(-a[c]) : ACC_W'(a[c]);
      o = o | m;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ux_r[c]   <= pacc_r[c][ACC_W-1] ? ACC_W'(-pacc_r[c]) : ACC_W'(pacc_r[c]);
        pneg_r[c] <= pacc_r[c][ACC_W-1] ^ pacc_r[3][ACC_W-1];
        nmag_r[c] <= nacc_r[c][ACC_W-1] ? ACC_W'(-nacc_r[c]) : ACC_W'(nacc_r[c]);
      end
      uw_r  <= pacc_r[3][ACC_W-1] ? ACC_W'(-pacc_r[3]) : ACC_W'(pacc_r[3]);
      wz_r  <= (pacc_r[3] == '0);
      orw_r <= ACC_W'(nacc_nxt_or(nacc_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        nneg_r[c] <= nacc_r[c][ACC_W-1];
      end
    end
  end

  // normal sign and zero flag ride a delay line from stage 3
  always_comb begin
    nside_nxt = {(orw_r == '0), nneg_r};
  end

  // ------------------------------ stage 4: divide setup, coarse leading one
  logic [NUM_W-1:0] pnum [3];
  logic [ACC_W-1:0] phi_r [3];
  logic [QB-1:0]    plo_r [3];
  logic [ACC_W-1:0] uw4_r;
  logic [2:0]       povf_r;
  logic [2:0]       pneg4_r;
  logic             wz4_r;
  logic [NG*8-1:0]  orw_pad;
  logic [GW-1:0]    grp_nxt;
  logic [GW-1:0]    grp_r;
  logic [NG*8-1:0]  orw4_r;
  logic [ACC_W-1:0] nmag4_r [3];
  logic [3:0]       nside4_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pnum[c] = {ux_r[c], {F{1'b0}}};
    end
    orw_pad = (NG*8)'(orw_r);
    grp_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (|orw_pad[g*8 +: 8]) begin
        grp_nxt = GW'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        povf_r[c] <= (pnum[c] >> QB) >= NUM_W'(uw_r);
        phi_r[c]  <= ACC_W'(pnum[c] >> QB);
        plo_r[c]  <= pnum[c][QB-1:0];
      end
      uw4_r    <= uw_r;
      pneg4_r  <= pneg_r;
      wz4_r    <= wz_r;
      grp_r    <= grp_nxt;
      orw4_r   <= orw_pad;
      nmag4_r  <= nmag_r;
      nside4_r <= nside_nxt;
    end
  end

  // --------------------------------------- position dividers (from stage 4)
  logic [QB-1:0] pq [3];

  for (genvar c = 0; c < 3; c++) begin : g_pdiv
    vtu_div_pipe #(.DEN_W(ACC_W), .Q_BITS(QB)) u_pdiv (
      .clk    (clk),
      .en     (en),
      .rem_in (phi_r[c]),
      .lo_in  (plo_r[c]),
      .den_in (uw4_r),
      .quo    (pq[c])
    );
  end

  // --------------------------------------- stage 5: fine leading one
  logic [7:0]       byte_sel;
  logic [2:0]       bpos;
  logic [PW-1:0]    lpos_r;
  logic [ACC_W-1:0] nmag5_r [3];
  logic [3:0]       nside5_r;

  always_comb begin
    byte_sel = orw4_r[grp_r*8 +: 8];
    bpos     = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_sel[b]) begin
        bpos = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpos_r   <= {grp_r, bpos};
      nmag5_r  <= nmag4_r;
      nside5_r <= nside4_r;
    end
  end

  // --------------------------------------- stage 6: normalize
  logic [vtu_pkg::NRM_BITS-1:0] m30_nxt [3];
  logic [vtu_pkg::NRM_BITS-1:0] m30_r [3];
  logic [3:0]                   nside6_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (lpos_r >= PW'(vtu_pkg::NRM_TOP)) begin
        m30_nxt[c] = vtu_pkg::NRM_BITS'(nmag5_r[c] >> (lpos_r - PW'(vtu_pkg::NRM_TOP)));
      end else begin
        m30_nxt[c] = vtu_pkg::NRM_BITS'(nmag5_r[c] << (PW'(vtu_pkg::NRM_TOP) - lpos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m30_r    <= m30_nxt;
      nside6_r <= nside5_r;
    end
  end

  // --------------------------------------- stages 7, 8: sum of squares
  logic [vtu_pkg::SQ_W-1:0]    sq_r [3];
  logic [vtu_pkg::SUMSQ_W-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= vtu_pkg::SQ_W'(m30_r[c]) * vtu_pkg::SQ_W'(m30_r[c]);
      end
      s2_r <= vtu_pkg::SUMSQ_W'(sq_r[0]) + vtu_pkg::SUMSQ_W'(sq_r[1])
            + vtu_pkg::SUMSQ_W'(sq_r[2]);
    end
  end

  logic [vtu_pkg::ROOT_W-1:0] root;

  vtu_isqrt_pipe u_isqrt (
    .clk  (clk),
    .en   (en),
    .n_in (vtu_pkg::ISQ_W'(s2_r)),
    .root (root)
  );

  // hold the normalized components until the root is out
  logic [vtu_pkg::NRM_BITS-1:0] m30_d_r [M_DLY][3];

  always_ff @(posedge clk) begin
    if (en) begin
      m30_d_r[0] <= m30_r;
      for (int k = 1; k < M_DLY; k++) begin
        m30_d_r[k] <= m30_d_r[k-1];
      end
    end
  end

  // --------------------------------------- normal dividers (from root)
  logic [QN-1:0] nq [3];

  for (genvar c = 0; c < 3; c++) begin : g_ndiv
    vtu_div_pipe #(.DEN_W(vtu_pkg::ROOT_W), .Q_BITS(QN)) u_ndiv (
      .clk    (clk),
      .en     (en),
      .rem_in (vtu_pkg::ROOT_W'(m30_d_r[M_DLY-1][c] >> 1)),
      .lo_in  ({m30_d_r[M_DLY-1][c][0], {F{1'b0}}}),
      .den_in (root),
      .quo    (nq[c])
    );
  end

  // --------------------------------------- side delay lines to S_END
  logic [PASS_W-1:0] pass_d_r  [S_END];
  logic [3:0]        nside_d_r [S_END-6];
  logic [6:0]        pside_d_r [S_END-4];
  logic [QB-1:0]     pq_d_r    [PDLY][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pass_d_r[0]  <= {in_ch.data.tex_u, in_ch.data.tex_v, in_ch.data.last_vertex};
      nside_d_r[0] <= nside6_r;
      pside_d_r[0] <= {wz4_r, pneg4_r, povf_r};
      pq_d_r[0]    <= pq;
      for (int k = 1; k < S_END; k++) begin
        pass_d_r[k] <= pass_d_r[k-1];
      end
      for (int k = 1; k < S_END - 6; k++) begin
        nside_d_r[k] <= nside_d_r[k-1];
      end
      for (int k = 1; k < S_END - 4; k++) begin
        pside_d_r[k] <= pside_d_r[k-1];
      end
      for (int k = 1; k < PDLY; k++) begin
        pq_d_r[k] <= pq_d_r[k-1];
      end
    end
  end

  // --------------------------------------- final stage: sign and clip
  localparam logic [SW-1:0] LIM_POS = (SW'(1) << (OUT_W - 1)) - SW'(1);
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (OUT_W - 1);

  logic [6:0]        pside;
  logic [3:0]        nside;
  logic [PASS_W-1:0] pass;
  logic [SW-1:0]     mag    [6];
  logic [SW-1:0]     lim    [6];
  logic [SW-1:0]     val    [6];
  logic [5:0]        neg;
  logic [5:0]        clip;
  logic [5:0]        force0;
  vtu_pkg::vtu_out_t res_nxt;
  vtu_pkg::vtu_out_t out_r;

  always_comb begin
    pside = pside_d_r[S_END-5];
    nside = nside_d_r[S_END-7];
    pass  = pass_d_r[S_END-1];
    for (int c = 0; c < 3; c++) begin
      mag[c]      = SW'(pq_d_r[PDLY-1][c]);
      neg[c]      = pside[3 + c];
      force0[c]   = pside[6];
      mag[3 + c]  = SW'(nq[c]);
      neg[3 + c]  = nside[c];
      force0[3+c] = nside[3];
    end
    for (int i = 0; i < 6; i++) begin
      lim[i]  = neg[i] ? LIM_NEG : LIM_POS;
      clip[i] = !force0[i] && ((i < 3 && pside[i]) || mag[i] > lim[i]);
      val[i]  = clip[i] ? lim[i] : mag[i];
      val[i]  = force0[i] ? '0 : (neg[i] ? SW'(-val[i]) : val[i]);
    end
    res_nxt.out_x       = val[0][FW-1:0];
    res_nxt.out_y       = val[1][FW-1:0];
    res_nxt.out_z       = val[2][FW-1:0];
    res_nxt.out_nx      = val[3][FW-1:0];
    res_nxt.out_ny      = val[4][FW-1:0];
    res_nxt.out_nz      = val[5][FW-1:0];
    res_nxt.out_u       = pass[PASS_W-1 -: FW];
    res_nxt.out_v       = pass[FW:1];
    res_nxt.out_last    = pass[0];
    res_nxt.w_zero      = pside[6];
    res_nxt.normal_zero = nside[3];
    res_nxt.saturated   = |clip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid = vld_r[LAT];
  assign out_ch.data  = out_r;

  // ------------------------------------------------------------ checks
  a_wzero_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.w_zero |->
      out_ch.data.out_x == '0 && out_ch.data.out_y == '0 && out_ch.data.out_z == '0)
    else $error("w_zero result with nonzero position");

  a_nzero_clears_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.normal_zero |->
      out_ch.data.out_nx == '0 && out_ch.data.out_ny == '0 && out_ch.data.out_nz == '0)
    else $error("normal_zero result with nonzero normal");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the pipeline is stalled");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $countones(vld_r) == $past($countones(vld_r)))
    else $error("items lost or created during a stall");

endmodule
